/* rtl/lcsb_pkg.sv */
package lcsb_pkg;

  localparam int SLOT_COUNT  = 256;
  localparam int MAX_NESTING = 8;

  localparam int PTR_W  = $clog2(SLOT_COUNT);
  localparam int STK_W  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int LVL_W  = 4;
  localparam int KIND_W = 3;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 8;
  localparam int ENT_W  = KIND_W + DATA_W;

  // loop end entry layout inside the data word
  localparam int F_START_LSB = 0;
  localparam int F_LVL_LSB   = 8;
  localparam int F_CNT_LSB   = 12;
  localparam int F_REP_LSB   = 20;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    K_COLOR    = 3'd0,
    K_FADE     = 3'd1,
    K_LOOP_ON  = 3'd2,
    K_LOOP_OFF = 3'd3,
    K_DELETE   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_COLOR = 2'd1,
    ACT_FADE  = 2'd2
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic              op;
    logic [KIND_W-1:0] cmd_kind;
    logic [DATA_W-1:0] cmd_payload;
    logic [CNT_W-1:0]  loop_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] action_payload;
    logic              add_accepted;
    logic              entries_pending;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(SLOT_COUNT - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

/* rtl/looping_command_script_buffer_top.sv */
// timing: an add or an empty run tick shows its result in the cycle after the transfer;
// an executing run tick first reads the ring memory; its result is registered after that
// throughput: adds one per cycle while busy is low; an executing run tick takes no new
// transfer while busy; the receiver cannot stall, each result is a one-cycle strobe
// reset clears pointers, nesting level and flags; ring and loop stack are not cleared
module looping_command_script_buffer_top
  import lcsb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

  state_e state_q, state_d;

  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] eptr_q, eptr_d;
  logic             in_loop_q, in_loop_d;
  logic             clr_q, clr_d;
  logic             done_q, done_d;
  res_t             out_q, out_d;

  logic [PTR_W-1:0] stack_q [MAX_NESTING];
  logic             stk_we;
  logic [STK_W-1:0] stk_idx;

  logic [ENT_W-1:0] mem [SLOT_COUNT];
  logic [ENT_W-1:0] rd_q;
  logic             mem_we;
  logic             mem_re;
  logic [PTR_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  logic             exec_go;
  logic             accept;
  logic [PTR_W-1:0] nxt_w;
  logic [PTR_W-1:0] nxt_e;
  logic             full;
  logic [LVL_W-1:0] lvl_m1;
  logic [DATA_W-1:0] off_data;

  logic [KIND_W-1:0] rd_kind;
  logic [DATA_W-1:0] rd_data;
  logic [PTR_W-1:0]  rd_start;
  logic [LVL_W-1:0]  rd_depth;
  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  rd_reps;
  logic [DATA_W-1:0] rd_keep;

  assign accept  = start && (state_q == ST_IDLE);
  assign nxt_w   = ptr_next(wptr_q);
  assign nxt_e   = ptr_next(eptr_q);
  assign full    = (nxt_w == rptr_q);
  assign lvl_m1  = lvl_q - LVL_W'(1);

  assign rd_kind  = rd_q[ENT_W-1 -: KIND_W];
  assign rd_data  = rd_q[DATA_W-1:0];
  assign rd_start = rd_data[F_START_LSB +: PTR_W];
  assign rd_depth = rd_data[F_LVL_LSB +: LVL_W];
  assign rd_cnt   = rd_data[F_CNT_LSB +: CNT_W];
  assign rd_reps  = rd_data[F_REP_LSB +: CNT_W];

  always_comb begin
    rd_keep = rd_data;
    rd_keep[F_CNT_LSB +: CNT_W] = '0;
  end

  always_comb begin
    off_data = '0;
    off_data[F_START_LSB +: PTR_W] = ptr_next(stack_q[lvl_m1[STK_W-1:0]]);
    off_data[F_LVL_LSB +: LVL_W]   = lvl_m1;
    off_data[F_CNT_LSB +: CNT_W]   = cmd_i.loop_count;
    off_data[F_REP_LSB +: CNT_W]   = cmd_i.loop_count;
  end

  // main datapath: add handling, run tick start and the execute step
  always_comb begin
    lvl_d     = lvl_q;
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    eptr_d    = eptr_q;
    in_loop_d = in_loop_q;
    clr_d     = clr_q;
    out_d     = '0;
    done_d    = 1'b0;
    exec_go   = 1'b0;
    stk_we    = 1'b0;
    stk_idx   = lvl_q[STK_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = wptr_q;
    mem_wdata = '0;

    if (accept) begin
      done_d = 1'b1;
      if (cmd_i.op == OP_ADD) begin
        if (!clr_q) begin
          case (cmd_i.cmd_kind)
            K_DELETE: begin
              clr_d = 1'b1;
              out_d.add_accepted = 1'b1;
            end
            K_COLOR, K_FADE: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_wdata = {cmd_i.cmd_kind, cmd_i.cmd_payload};
                wptr_d    = nxt_w;
                out_d.add_accepted = 1'b1;
              end
            end
            K_LOOP_ON: begin
              if (lvl_q < LVL_W'(MAX_NESTING)) begin
                stk_we = 1'b1;
                lvl_d  = lvl_q + LVL_W'(1);
                if (!full) begin
                  mem_we    = 1'b1;
                  mem_wdata = {K_LOOP_ON, {DATA_W{1'b0}}};
                  wptr_d    = nxt_w;
                  out_d.add_accepted = 1'b1;
                end
              end
            end
            K_LOOP_OFF: begin
              if (lvl_q != '0) begin
                lvl_d = lvl_m1;
                if (!full) begin
                  mem_we    = 1'b1;
                  mem_wdata = {K_LOOP_OFF, off_data};
                  wptr_d    = nxt_w;
                  out_d.add_accepted = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (clr_q) begin
        // pending clear: pointers back to slot 0, nothing left to run
        in_loop_d = 1'b0;
        rptr_d    = '0;
        wptr_d    = '0;
        eptr_d    = '0;
        clr_d     = 1'b0;
      end else if (eptr_q != wptr_q) begin
        done_d  = 1'b0;
        exec_go = 1'b1;
      end
    end else if (state_q == ST_EXEC) begin
      done_d    = 1'b1;
      mem_waddr = eptr_q;
      case (rd_kind)
        K_LOOP_ON: begin
          eptr_d    = nxt_e;
          in_loop_d = 1'b1;
        end
        K_LOOP_OFF: begin
          if (rd_cnt == '0) begin
            eptr_d = rd_start;
          end else if (rd_cnt > CNT_W'(1)) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_kind, rd_keep};
            mem_wdata[F_CNT_LSB +: CNT_W] = rd_cnt - CNT_W'(1);
            eptr_d    = rd_start;
          end else if (rd_depth == '0) begin
            // end of the outermost loop frees the whole body
            eptr_d    = nxt_e;
            rptr_d    = nxt_e;
            in_loop_d = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {rd_kind, rd_keep};
            mem_wdata[F_CNT_LSB +: CNT_W] = rd_reps;
            eptr_d    = nxt_e;
          end
        end
        default: begin
          out_d.action         = (rd_kind == K_FADE) ? ACT_FADE : ACT_COLOR;
          out_d.action_payload = rd_data;
          eptr_d               = nxt_e;
          if (!in_loop_q) begin
            rptr_d = nxt_e;
          end
        end
      endcase
    end

    out_d.entries_pending = (eptr_d != wptr_d);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (exec_go) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_q == ST_EXEC);
    mem_re = exec_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lvl_q     <= '0;
      rptr_q    <= '0;
      wptr_q    <= '0;
      eptr_q    <= '0;
      in_loop_q <= 1'b0;
      clr_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      rptr_q    <= rptr_d;
      wptr_q    <= wptr_d;
      eptr_q    <= eptr_d;
      in_loop_q <= in_loop_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (stk_we) begin
      stack_q[stk_idx] <= wptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[eptr_q];
    end
  end

  assign done_o = done_q;
  assign res_o  = out_q;

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("execute state lasted more than one cycle");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> done_o)
    else $error("execute step gave no result");

  a_add_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.op == OP_ADD) |=> (done_o && res_o.action == ACT_NONE))
    else $error("add transfer gave no plain result in the next cycle");

  a_action_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.action != ACT_NONE) |-> ($past(state_q) == ST_EXEC))
    else $error("action emitted without an execute step");

  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("ring write and read issued in the same cycle");

endmodule
